// ----- rtl/core/cecrx_pkg.sv -----
// cecrx_pkg: shared types, timing windows and codes of the cec edge receiver
// no dependencies; imported by every rtl/core module of the receiver

package cecrx_pkg;

  localparam int unsigned TIME_W        = 32;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned INDEX_W       = 4;
  localparam int unsigned FRAME_LEN_W   = 5;
  localparam int unsigned MAX_BYTES     = 16;
  localparam int unsigned BYTE_CNT_W    = $clog2(MAX_BYTES + 1);
  localparam int unsigned BIT_CNT_W     = 4;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned IN_DATA_W     = 32;
  localparam int unsigned OUT_DATA_W    = 24;

  localparam logic [ADDR_W-1:0] ADDR_NONE = 4'hf;

  // timing windows in microseconds
  localparam logic [TIME_W-1:0] START_LOW_MIN  = 32'd3500;
  localparam logic [TIME_W-1:0] START_LOW_MAX  = 32'd3900;
  localparam logic [TIME_W-1:0] START_PER_MIN  = 32'd4300;
  localparam logic [TIME_W-1:0] START_PER_MAX  = 32'd4700;
  localparam logic [TIME_W-1:0] BIT_PER_MIN    = 32'd2050;
  localparam logic [TIME_W-1:0] BIT_PER_MAX    = 32'd2750;
  localparam logic [TIME_W-1:0] ONE_LOW_MIN    = 32'd400;
  localparam logic [TIME_W-1:0] ONE_LOW_MAX    = 32'd800;
  localparam logic [TIME_W-1:0] ZERO_LOW_MIN   = 32'd1300;
  localparam logic [TIME_W-1:0] ZERO_LOW_MAX   = 32'd1700;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              rising;
  } edge_item_t;

  typedef struct packed {
    event_e                 event_res;
    logic [BYTE_W-1:0]      data_byte;
    logic [INDEX_W-1:0]     byte_index;
    logic                   end_of_message;
    logic                   pull_ack;
    logic [FRAME_LEN_W-1:0] frame_length;
  } result_t;

endpackage

// ----- rtl/core/cecrx_in_reg.sv -----
// cecrx_in_reg: input register for timestamped line edges
// depends on cecrx_pkg

module cecrx_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [31:0]           s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  adv_i,
  output logic                  valid_o,
  output cecrx_pkg::edge_item_t item_o
);
  import cecrx_pkg::*;

  logic       valid_q, valid_d;
  edge_item_t item_q;

  assign s_tready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (s_tready_o) begin
      valid_d = s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      item_q.time_us <= s_tdata_i[TIME_W-1:0];
      item_q.rising  <= s_tuser_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/core/cecrx_fsm.sv -----
// cecrx_fsm: frame state, bit timing checks and bit decode, one edge per step
// depends on cecrx_pkg

module cecrx_fsm (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  cecrx_pkg::edge_item_t   item_i,
  input  logic [3:0]              own_addr_i,
  output logic                    res_valid_o,
  output cecrx_pkg::result_t      res_o
);
  import cecrx_pkg::*;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_START_HIGH = 3'd1;
  localparam logic [2:0] PH_DATA_LOW   = 3'd2;
  localparam logic [2:0] PH_DATA_HIGH  = 3'd3;
  localparam logic [2:0] PH_EOM_LOW    = 3'd4;
  localparam logic [2:0] PH_EOM_HIGH   = 3'd5;
  localparam logic [2:0] PH_ACK_LOW    = 3'd6;
  localparam logic [2:0] PH_ACK_HIGH   = 3'd7;

  logic [2:0]            phase_q, phase_d;
  logic [TIME_W-1:0]     ref_q, ref_d;
  logic                  first_q, first_d;
  logic [BYTE_CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [BYTE_W-1:0]     shift_q, shift_d;
  logic [ADDR_W-1:0]     hdr_dst_q, hdr_dst_d;
  logic                  eom_q, eom_d;

  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] per_lo, per_hi;
  logic              is_one, is_zero, bit_bad, per_bad;
  logic              do_abort;

  assign dt      = item_i.time_us - ref_q;
  assign is_one  = (dt >= ONE_LOW_MIN) && (dt <= ONE_LOW_MAX);
  assign is_zero = (dt >= ZERO_LOW_MIN) && (dt <= ZERO_LOW_MAX);
  assign bit_bad = !is_one && !is_zero;
  assign per_lo  = first_q ? START_PER_MIN : BIT_PER_MIN;
  assign per_hi  = first_q ? START_PER_MAX : BIT_PER_MAX;
  assign per_bad = (dt < per_lo) || (dt > per_hi);

  always_comb begin
    phase_d     = phase_q;
    ref_d       = ref_q;
    first_d     = first_q;
    byte_cnt_d  = byte_cnt_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    hdr_dst_d   = hdr_dst_q;
    eom_d       = eom_q;
    do_abort    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (!item_i.rising) begin
            ref_d   = item_i.time_us;
            phase_d = PH_START_HIGH;
          end
        end
        PH_START_HIGH: begin
          if (item_i.rising) begin
            if ((dt < START_LOW_MIN) || (dt > START_LOW_MAX)) begin
              do_abort = 1'b1;
            end else begin
              first_d    = 1'b1;
              byte_cnt_d = '0;
              bit_cnt_d  = '0;
              shift_d    = '0;
              hdr_dst_d  = ADDR_NONE;
              eom_d      = 1'b0;
              phase_d    = PH_DATA_LOW;
            end
          end
        end
        PH_DATA_LOW, PH_EOM_LOW: begin
          if (!item_i.rising) begin
            if (per_bad) begin
              do_abort = 1'b1;
            end else begin
              ref_d   = item_i.time_us;
              first_d = 1'b0;
              phase_d = (phase_q == PH_EOM_LOW) ? PH_EOM_HIGH : PH_DATA_HIGH;
            end
          end
        end
        PH_DATA_HIGH: begin
          if (item_i.rising) begin
            if (bit_bad) begin
              do_abort = 1'b1;
            end else begin
              shift_d   = {shift_q[BYTE_W-2:0], is_one};
              bit_cnt_d = bit_cnt_q + 1'b1;
              if (bit_cnt_d >= BIT_CNT_W'(BITS_PER_BYTE)) begin
                if (byte_cnt_q == '0) begin
                  hdr_dst_d = shift_d[ADDR_W-1:0];
                end
                phase_d = PH_EOM_LOW;
              end else begin
                phase_d = PH_DATA_LOW;
              end
            end
          end
        end
        PH_EOM_HIGH: begin
          if (item_i.rising) begin
            if (bit_bad) begin
              do_abort = 1'b1;
            end else begin
              eom_d   = is_one;
              phase_d = PH_ACK_LOW;
            end
          end
        end
        PH_ACK_LOW: begin
          if (!item_i.rising) begin
            ref_d                = item_i.time_us;
            byte_cnt_d           = byte_cnt_q + 1'b1;
            phase_d              = PH_ACK_HIGH;
            res_valid_o          = 1'b1;
            res_o.event_res      = EV_BYTE;
            res_o.data_byte      = shift_q;
            res_o.byte_index     = INDEX_W'(byte_cnt_q);
            res_o.end_of_message = eom_q;
            res_o.pull_ack       = (hdr_dst_q != ADDR_NONE) && (hdr_dst_q == own_addr_i);
          end
        end
        PH_ACK_HIGH: begin
          if (item_i.rising) begin
            if (bit_bad) begin
              do_abort = 1'b1;
            end else if (eom_q) begin
              phase_d            = PH_IDLE;
              res_valid_o        = 1'b1;
              res_o.event_res    = EV_DONE;
              res_o.frame_length = FRAME_LEN_W'(byte_cnt_q);
            end else if (byte_cnt_q >= BYTE_CNT_W'(MAX_BYTES)) begin
              do_abort = 1'b1;
            end else begin
              bit_cnt_d = '0;
              shift_d   = '0;
              phase_d   = PH_DATA_LOW;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      if (do_abort) begin
        phase_d         = PH_IDLE;
        res_valid_o     = 1'b1;
        res_o           = '0;
        res_o.event_res = EV_ABORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      ref_q      <= '0;
      first_q    <= 1'b0;
      byte_cnt_q <= '0;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      hdr_dst_q  <= ADDR_NONE;
      eom_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      ref_q      <= ref_d;
      first_q    <= first_d;
      byte_cnt_q <= byte_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      hdr_dst_q  <= hdr_dst_d;
      eom_q      <= eom_d;
    end
  end

endmodule

// ----- rtl/core/cecrx_out_reg.sv -----
// cecrx_out_reg: result register on the master side of the receiver
// depends on cecrx_pkg

module cecrx_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_valid_i,
  input  cecrx_pkg::result_t res_i,
  output logic               adv_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output cecrx_pkg::result_t res_o
);
  import cecrx_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign adv_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && load_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign res_o      = res_q;

endmodule

// ----- rtl/core/cec_edge_timed_frame_receiver.sv -----
// cec_edge_timed_frame_receiver: top level of the cec edge-timed frame receiver
// depends on cecrx_pkg, cecrx_in_reg, cecrx_fsm, cecrx_out_reg
//
// usage:
//   slave side carries one line edge per transfer: tdata is the microsecond
//   timestamp, tuser is 1 for a rising edge and 0 for a falling edge.
//   master side carries at most one event per edge: tuser is the event kind
//   (byte, frame complete, abort), tlast the byte's end-of-message bit,
//   tdata the byte, its index, the acknowledge pull flag and the frame length.
//   the cfg channel writes the 4-bit own address; it is always ready. the user
//   must write it only while no edge is in flight; the block does not check it.
// path: an accepted edge is registered in the input register, processed by the
//   frame state logic, and its event is registered in the output register.
// throughput: one edge per cycle while the master side takes events.
// reset: no frame in progress, own address 15 (never acknowledge), both
//   registers empty.
// stall: a stalled master side holds its event; one more edge is taken into
//   the input register, then tready drops until the event is transferred.

module cec_edge_timed_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] edge_time_us
  input  logic        s_axis_tuser_i,  // [0] rising
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] data_byte, [11:8] byte_index,
                                       // [12] pull_ack, [17:13] frame_length
  output logic [1:0]  m_axis_tuser_o,  // [1:0] event_res
  output logic        m_axis_tlast_o,  // end_of_message
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i       // [3:0] own_address
);
  import cecrx_pkg::*;

  logic [ADDR_W-1:0] own_addr_q;
  logic              in_valid;
  edge_item_t        in_item;
  logic              adv;
  logic              step;
  logic              res_valid;
  result_t           res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= ADDR_NONE;
    end else if (cfg_valid_i) begin
      own_addr_q <= cfg_data_i;
    end
  end

  cecrx_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .adv_i      (adv),
    .valid_o    (in_valid),
    .item_o     (in_item)
  );

  assign step = in_valid && adv;

  cecrx_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item),
    .own_addr_i  (own_addr_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cecrx_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .res_i        (res),
    .adv_o        (adv),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .res_o        (out_res)
  );

  assign m_axis_tdata_o = {6'd0, out_res.frame_length, out_res.pull_ack,
                           out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser_o = out_res.event_res;
  assign m_axis_tlast_o = out_res.end_of_message;

  a_result_reaches_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step && res_valid |=> m_axis_tvalid_o
  ) else $error("processed event did not reach the output register");

  a_free_output_takes_edge: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o
  ) else $error("input stalled with an empty output register");

  a_length_only_on_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_res.event_res != EV_DONE) |-> out_res.frame_length == '0
  ) else $error("frame length on an event other than frame complete");

  a_ack_only_on_byte: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res.pull_ack |-> out_res.event_res == EV_BYTE
  ) else $error("acknowledge pull on an event other than byte");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for cec_edge_timed_frame_receiver, line edges in, frame events out
// depends on cecrx_pkg and the receiver rtl; holds its own frame predictor in a scoreboard class

module tb;
  import cecrx_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 3000;

  class cec_frame_scoreboard;
    typedef enum logic [2:0] {
      RX_IDLE, RX_START_HI, RX_BIT_LO, RX_BIT_HI, RX_EOM_LO, RX_EOM_HI, RX_ACK_LO, RX_ACK_HI
    } rx_state_e;

    rx_state_e   state = RX_IDLE;
    logic [31:0] ref_t = '0;
    logic        first_pending = 1'b0;
    logic [5:0]  byte_cnt = '0;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shift = '0;
    logic [3:0]  hdr_dest = ADDR_NONE;
    logic        eom_bit = 1'b0;
    logic [3:0]  own_addr = ADDR_NONE;
    result_t     event_q[$];
    int          errors, n_edges, n_bytes, n_acks, n_done, n_abort;

    function int bit_value(logic [31:0] low);
      if (low >= ONE_LOW_MIN && low <= ONE_LOW_MAX) return 1;
      if (low >= ZERO_LOW_MIN && low <= ZERO_LOW_MAX) return 0;
      return -1;
    endfunction

    function void push_abort();
      result_t r;
      r = '0;
      r.event_res = EV_ABORT;
      state = RX_IDLE;
      event_q.push_back(r);
      n_abort++;
    endfunction

    // predicted reaction to one transferred edge
    function void note_edge(logic [31:0] t, logic rising);
      logic [31:0] dt;
      logic [31:0] lo;
      logic [31:0] hi;
      result_t     r;
      int          b;
      dt = t - ref_t;
      n_edges++;
      case (state)
        RX_IDLE: if (!rising) begin
          ref_t = t;
          state = RX_START_HI;
        end
        RX_START_HI: if (rising) begin
          if (dt < START_LOW_MIN || dt > START_LOW_MAX) push_abort();
          else begin
            first_pending = 1'b1;
            byte_cnt = '0;
            bit_cnt = '0;
            shift = '0;
            hdr_dest = ADDR_NONE;
            eom_bit = 1'b0;
            state = RX_BIT_LO;
          end
        end
        RX_BIT_LO, RX_EOM_LO: if (!rising) begin
          lo = first_pending ? START_PER_MIN : BIT_PER_MIN;
          hi = first_pending ? START_PER_MAX : BIT_PER_MAX;
          if (dt < lo || dt > hi) push_abort();
          else begin
            ref_t = t;
            first_pending = 1'b0;
            state = (state == RX_EOM_LO) ? RX_EOM_HI : RX_BIT_HI;
          end
        end
        RX_BIT_HI: if (rising) begin
          b = bit_value(dt);
          if (b < 0) push_abort();
          else begin
            shift = {shift[6:0], b[0]};
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              if (byte_cnt == 0) hdr_dest = shift[3:0];
              state = RX_EOM_LO;
            end else begin
              state = RX_BIT_LO;
            end
          end
        end
        RX_EOM_HI: if (rising) begin
          b = bit_value(dt);
          if (b < 0) push_abort();
          else begin
            eom_bit = b[0];
            state = RX_ACK_LO;
          end
        end
        RX_ACK_LO: if (!rising) begin
          // slot opening carries no period check
          ref_t = t;
          r = '0;
          r.event_res = EV_BYTE;
          r.data_byte = shift;
          r.byte_index = byte_cnt[3:0];
          r.end_of_message = eom_bit;
          r.pull_ack = (hdr_dest != ADDR_NONE) && (hdr_dest == own_addr);
          event_q.push_back(r);
          n_bytes++;
          if (r.pull_ack) n_acks++;
          byte_cnt = byte_cnt + 1'b1;
          state = RX_ACK_HI;
        end
        RX_ACK_HI: if (rising) begin
          if (bit_value(dt) < 0) push_abort();
          else if (eom_bit) begin
            r = '0;
            r.event_res = EV_DONE;
            r.frame_length = byte_cnt[4:0];
            event_q.push_back(r);
            n_done++;
            state = RX_IDLE;
          end else if (byte_cnt >= MAX_BYTES) push_abort();
          else begin
            bit_cnt = '0;
            shift = '0;
            state = RX_BIT_LO;
          end
        end
        default: state = RX_IDLE;
      endcase
    endfunction

    function void compare_field(string fld, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, fld, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (event_q.size() == 0) begin
        errors++;
        $display("%0t unexpected event: expected none, actual kind %0d byte 0x%0h",
                 $time, got.event_res, got.data_byte);
        return;
      end
      want = event_q.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("end_of_message", want.end_of_message, got.end_of_message);
      compare_field("pull_ack", want.pull_ack, got.pull_ack);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction

    function int pending();
      return event_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        edge_valid;
  logic        edge_ready;
  logic [31:0] edge_data;
  logic        edge_user;
  logic        evt_valid;
  logic        evt_ready;
  logic [23:0] evt_data;
  logic [1:0]  evt_user;
  logic        evt_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  cec_frame_scoreboard sb = new;
  edge_item_t  edge_q[$];
  logic [31:0] fall_t;
  logic [3:0]  cur_addr;
  int          noise_pct = 0;
  int          bytes_built = 0;
  int          n_cfg = 0;
  int          n_holds = 0;
  int          n_pauses = 0;
  int          rx_cycle = 0;
  int          idle_cycles = 0;
  bit          hold_pending = 1'b0;
  result_t     seen_event;

  cec_edge_timed_frame_receiver DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (edge_valid),
    .s_axis_tready_o (edge_ready),
    .s_axis_tdata_i  (edge_data),
    .s_axis_tuser_i  (edge_user),
    .m_axis_tvalid_o (evt_valid),
    .m_axis_tready_i (evt_ready),
    .m_axis_tdata_o  (evt_data),
    .m_axis_tuser_o  (evt_user),
    .m_axis_tlast_o  (evt_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --- stimulus construction ---

  function automatic logic [31:0] pick_time(logic [31:0] lo, logic [31:0] hi);
    if ($urandom_range(0, 99) < noise_pct) begin
      case ($urandom_range(0, 2))
        0: return lo - 1;
        1: return hi + 1;
        default: return $urandom_range(0, 6000);
      endcase
    end
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [31:0] cell_low_us(logic one);
    return one ? pick_time(ONE_LOW_MIN, ONE_LOW_MAX) : pick_time(ZERO_LOW_MIN, ZERO_LOW_MAX);
  endfunction

  function automatic void put_edge(logic [31:0] t, logic rising);
    edge_q.push_back(edge_item_t'{time_us: t, rising: rising});
  endfunction

  // one bit cell: falling edge after period, rising edge after low time, with stray edges at the noise rate
  function automatic void put_bit(logic [31:0] period, logic [31:0] low);
    fall_t = fall_t + period;
    put_edge(fall_t, 1'b0);
    if ($urandom_range(0, 99) < noise_pct) put_edge($urandom(), 1'b0);
    put_edge(fall_t + low, 1'b1);
    if ($urandom_range(0, 99) < noise_pct) put_edge($urandom(), 1'b1);
  endfunction

  function automatic void build_frame(int n, logic [3:0] dest, logic [31:0] t0);
    logic [31:0] period;
    logic [31:0] ack_low;
    logic [7:0]  value;
    fall_t = t0;
    put_edge(fall_t, 1'b0);
    put_edge(fall_t + pick_time(START_LOW_MIN, START_LOW_MAX), 1'b1);
    period = pick_time(START_PER_MIN, START_PER_MAX);
    for (int i = 0; i < n; i++) begin
      value = $urandom_range(0, 255);
      if (i == 0) value[3:0] = dest;
      for (int k = 7; k >= 0; k--) begin
        put_bit(period, cell_low_us(value[k]));
        period = pick_time(BIT_PER_MIN, BIT_PER_MAX);
      end
      put_bit(period, cell_low_us(i == n - 1));
      ack_low = ($urandom_range(0, 24) == 0) ? $urandom_range(801, 1299)
                                             : cell_low_us(1'($urandom_range(0, 1)));
      put_bit(($urandom_range(0, 3) == 0) ? $urandom() : pick_time(BIT_PER_MIN, BIT_PER_MAX),
              ack_low);
      period = pick_time(BIT_PER_MIN, BIT_PER_MAX);
    end
    bytes_built += n;
  endfunction

  function automatic logic [31:0] next_start();
    return ($urandom_range(0, 3) == 0) ? $urandom() : fall_t + $urandom_range(5000, 100000);
  endfunction

  function automatic logic [3:0] pick_dest();
    return $urandom_range(0, 1) ? cur_addr : 4'($urandom_range(0, 15));
  endfunction

  function automatic void build_random(int min_edges, int min_bytes);
    int e0;
    int b0;
    int n;
    e0 = edge_q.size();
    b0 = bytes_built;
    while (edge_q.size() - e0 < min_edges || bytes_built - b0 < min_bytes) begin
      noise_pct = ($urandom_range(0, 9) < 3) ? 4 : 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_BYTES) : $urandom_range(1, 4);
      build_frame(n, pick_dest(), next_start());
    end
    noise_pct = 0;
  endfunction

  function automatic void build_directed();
    fall_t = 32'h0000_1000;
    put_edge(32'h0000_0800, 1'b1);
    put_edge(fall_t, 1'b0);
    put_edge(fall_t + START_LOW_MIN - 1, 1'b1);
    fall_t = fall_t + 10000;
    put_edge(fall_t, 1'b0);
    put_edge(fall_t + START_LOW_MAX + 1, 1'b1);
    fall_t = fall_t + 10000;
    put_edge(fall_t, 1'b0);
    put_edge(fall_t + START_LOW_MIN, 1'b1);
    put_edge(fall_t + START_PER_MAX + 1, 1'b0);
    // single-byte frame straddling timestamp wrap, addressed to us
    build_frame(1, cur_addr, 32'hFFFF_F000);
  endfunction

  // --- drivers ---

  task automatic write_own_address(logic [3:0] addr);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_addr = addr;
  endtask

  task automatic drive_edges(int pause_at);
    int burst;
    int gap;
    int sent;
    burst = 0;
    sent = 0;
    while (edge_q.size() != 0) begin
      if (sent == pause_at) begin
        edge_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        n_pauses++;
      end else if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          edge_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 16);
      end
      edge_valid <= 1'b1;
      edge_data  <= edge_q[0].time_us;
      edge_user  <= edge_q[0].rising;
      do @(posedge clk); while (!edge_ready);
      void'(edge_q.pop_front());
      sent++;
      if (burst > 0) burst--;
    end
    edge_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: rotating stall patterns, plus one long hold-off on request
  initial begin
    evt_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_pending) begin
        evt_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
        n_holds++;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: evt_ready <= 1'b1;
          1: evt_ready <= 1'($urandom_range(0, 1));
          2: evt_ready <= ($urandom_range(0, 3) == 0);
          default: evt_ready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // monitor: transfers seen at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.own_addr = cfg_data;
        n_cfg++;
      end
      if (edge_valid && edge_ready) sb.note_edge(edge_data, edge_user);
      if (evt_valid && evt_ready) begin
        seen_event.event_res      = event_e'(evt_user);
        seen_event.data_byte      = evt_data[7:0];
        seen_event.byte_index     = evt_data[11:8];
        seen_event.pull_ack       = evt_data[12];
        seen_event.frame_length   = evt_data[17:13];
        seen_event.end_of_message = evt_last;
        sb.check_result(seen_event);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (edge_valid && edge_ready) || (evt_valid && evt_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    edge_valid <= 1'b0;
    edge_data  <= '0;
    edge_user  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    cur_addr    = ADDR_NONE;
    fall_t      = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_own_address(4'd0);
        1: write_own_address(ADDR_NONE);
        2: write_own_address(4'($urandom_range(1, 14)));
        default: write_own_address(4'($urandom_range(0, 15)));
      endcase
      if (ph == 0) build_directed();
      if (ph == 2) build_frame(MAX_BYTES + 1, pick_dest(), next_start());
      else build_random(30, 1);
      if (ph == 1) hold_pending = 1'b1;
      drive_edges((ph == 2) ? edge_q.size() / 2 : -1);
    end
    settle();
    $display("covered %0d edges: %0d bytes (%0d acknowledged), %0d complete frames, %0d aborts",
             sb.n_edges, sb.n_bytes, sb.n_acks, sb.n_done, sb.n_abort);
    $display("%0d own-address writes, %0d long output holds, %0d input pauses until drained",
             n_cfg, n_holds, n_pauses);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cecrx_pkg.sv
rtl/core/cecrx_in_reg.sv
rtl/core/cecrx_fsm.sv
rtl/core/cecrx_out_reg.sv
rtl/core/cec_edge_timed_frame_receiver.sv
test/tb.sv
